[hw/rtl/ror_pkg.sv]
// ----------------------------------------------------------------------------
// ror_pkg: shared types and constants of the ray origin offset block
// Field widths, IEEE single constants, stage control and the stage-one
// record handed from the preparation stage to the adder pipeline.
// ----------------------------------------------------------------------------
package ror_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Axes  = 3;

  // IEEE single constants.
  localparam logic [7:0]  ExpMax      = 8'hFF;
  localparam logic [30:0] MagSmallLim = 31'h3D00_0000;  // 1/32
  localparam logic [31:0] QuietNan    = 32'h7FC0_0000;
  localparam logic [7:0]  ScaleShift  = 8'd16;          // 2^-16
  localparam logic [7:0]  ExpOne      = 8'd127;         // 1.0
  localparam logic [7:0]  ExpFracLo   = 8'd119;         // 2^-8
  localparam logic [7:0]  OffsetShift = 8'd142;         // 127 + 23 - 8
  localparam logic [31:0] OffsetSat   = 32'd256;

  // Stage load enables, one per register stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // Result of the preparation stage for one axis.
  typedef struct packed {
    logic        byp;    // result already final (integer path or special)
    logic [31:0] bbits;  // final result when byp is set
    logic [31:0] pbits;  // point, float path
    logic [31:0] sbits;  // normal scaled by 2^-16, float path
  } prep_t;

endpackage

[hw/rtl/ror_if.sv]
// ----------------------------------------------------------------------------
// ror_if: valid/ready channels of the ray origin offset block
// ror_in_if carries point and normal, ror_out_if carries the origin.
// ----------------------------------------------------------------------------
interface ror_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [31:0] normal_x;
  logic [31:0] normal_y;
  logic [31:0] normal_z;

  modport source (output valid, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, output ready);
endinterface

interface ror_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;

  modport source (output valid, origin_x, origin_y, origin_z, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, output ready);
endinterface

[hw/rtl/ror_prep.sv]
// ----------------------------------------------------------------------------
// ror_prep: first pipeline stage of one axis
// Chooses the path, forms the integer ulp offset result and the normal
// scaled by 2^-16 with round to nearest even.
// ----------------------------------------------------------------------------
module ror_prep (
  input  logic              clk,
  input  ror_pkg::pipe_en_t en,
  input  logic [31:0]       point,
  input  logic [31:0]       normal,
  output ror_pkg::prep_t    prep_r
);
  import ror_pkg::*;

  logic [7:0]  ne;
  logic        n_nan;
  logic        p_nan;
  logic        fpath;
  logic        p_neg;
  logic [23:0] off_mag;
  logic [7:0]  off_sh;
  logic [31:0] off;
  logic [31:0] ibits;
  logic [23:0] sm;
  logic [7:0]  ssh;
  logic [39:0] sext;
  logic        sinc;
  logic [31:0] sbits;
  logic        s_spec;
  logic [31:0] spec_bits;
  prep_t       prep_nxt;

  always_comb begin
    ne    = normal[30:23];
    n_nan = (ne == ExpMax) && (normal[22:0] != 23'd0);
    p_nan = (point[30:23] == ExpMax) && (point[22:0] != 23'd0);
    fpath = point[30:0] < MagSmallLim;
    p_neg = point[31] && !p_nan;

    // Integer offset: trunc(256 * n), saturated to +-256, zero for NaN.
    off_sh  = OffsetShift - ne;
    off_mag = {1'b1, normal[22:0]} >> off_sh[4:0];
    if (n_nan) begin
      off = 32'd0;
    end else if (ne >= ExpOne) begin
      off = OffsetSat;
    end else if (ne >= ExpFracLo) begin
      off = {8'd0, off_mag};
    end else begin
      off = 32'd0;
    end
    if (normal[31] != p_neg) begin
      off = 32'd0 - off;
    end
    ibits = point + off;

    // Scale by 2^-16; results below the normal range are rounded.
    sm   = {(ne != 8'd0), normal[22:0]};
    ssh  = (ne == 8'd0) ? ScaleShift : (ScaleShift + 8'd1 - ne);
    sext = {sm, 16'd0} >> ssh[4:0];
    sinc = sext[15] && ((sext[14:0] != 15'd0) || sext[16]);
    if (ne == ExpMax) begin
      sbits = normal;
    end else if (ne > ScaleShift) begin
      sbits = {normal[31], ne - ScaleShift, normal[22:0]};
    end else begin
      sbits = {normal[31], 7'd0, sext[39:16] + {23'd0, sinc}};
    end

    s_spec    = (ne == ExpMax);
    spec_bits = n_nan ? QuietNan : sbits;

    prep_nxt.byp   = !fpath || s_spec;
    prep_nxt.bbits = fpath ? spec_bits : ibits;
    prep_nxt.pbits = point;
    prep_nxt.sbits = sbits;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

[hw/rtl/ror_fadd.sv]
// ----------------------------------------------------------------------------
// ror_fadd: single precision adder of one axis, stages two to four
// Stage two swaps and aligns, stage three adds and counts leading zeros,
// stage four normalizes and rounds to nearest even.
// ----------------------------------------------------------------------------
module ror_fadd (
  input  logic              clk,
  input  ror_pkg::pipe_en_t en,
  input  ror_pkg::prep_t    prep,
  output logic [31:0]       origin_r
);
  import ror_pkg::*;

  function automatic logic [4:0] lead_zeros(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (v[i] && !found) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Stage two registers.
  logic        byp2_r, sgn2_r, sub2_r;
  logic [31:0] bb2_r;
  logic [7:0]  ea2_r;
  logic [26:0] xa2_r, xb2_r;
  // Stage three registers.
  logic        byp3_r, sgn3_r, sub3_r;
  logic [31:0] bb3_r;
  logic [7:0]  ea3_r;
  logic [27:0] sum3_r;
  logic [4:0]  lz3_r;

  logic [31:0] fa, fb;
  logic [7:0]  eea, eeb, d;
  logic [4:0]  dsat;
  logic [26:0] xbfull;
  logic [53:0] xext;
  logic [26:0] xb_nxt;
  logic [27:0] sum_nxt;
  logic [7:0]  shl;
  logic [26:0] t;
  logic [7:0]  e_res;
  logic [7:0]  e_fld;
  logic        rinc;
  logic [30:0] mag;
  logic        sgn_res;
  logic [31:0] origin_nxt;

  // Stage two: larger magnitude first, align the smaller with sticky.
  always_comb begin
    if (prep.pbits[30:0] >= prep.sbits[30:0]) begin
      fa = prep.pbits;
      fb = prep.sbits;
    end else begin
      fa = prep.sbits;
      fb = prep.pbits;
    end
    eea    = (fa[30:23] == 8'd0) ? 8'd1 : fa[30:23];
    eeb    = (fb[30:23] == 8'd0) ? 8'd1 : fb[30:23];
    d      = eea - eeb;
    dsat   = (d >= 8'd27) ? 5'd27 : d[4:0];
    xbfull = {(fb[30:23] != 8'd0), fb[22:0], 3'd0};
    xext   = {xbfull, 27'd0} >> dsat;
    xb_nxt = xext[53:27] | {26'd0, (xext[26:0] != 27'd0)};
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      byp2_r <= prep.byp;
      bb2_r  <= prep.bbits;
      sgn2_r <= fa[31];
      sub2_r <= fa[31] ^ fb[31];
      ea2_r  <= eea;
      xa2_r  <= {(fa[30:23] != 8'd0), fa[22:0], 3'd0};
      xb2_r  <= xb_nxt;
    end
  end

  // Stage three: add or subtract magnitudes.
  always_comb begin
    if (sub2_r) begin
      sum_nxt = {1'b0, xa2_r} - {1'b0, xb2_r};
    end else begin
      sum_nxt = {1'b0, xa2_r} + {1'b0, xb2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      byp3_r <= byp2_r;
      bb3_r  <= bb2_r;
      sgn3_r <= sgn2_r;
      sub3_r <= sub2_r;
      ea3_r  <= ea2_r;
      sum3_r <= sum_nxt;
      lz3_r  <= lead_zeros(sum_nxt[26:0]);
    end
  end

  // Stage four: normalize, stopping at the subnormal range, then round.
  always_comb begin
    shl = ({3'd0, lz3_r} < (ea3_r - 8'd1)) ? {3'd0, lz3_r} : (ea3_r - 8'd1);
    if (sum3_r[27]) begin
      t     = sum3_r[27:1] | {26'd0, sum3_r[0]};
      e_res = ea3_r + 8'd1;
    end else begin
      t     = sum3_r[26:0] << shl[4:0];
      e_res = ea3_r - shl;
    end
    e_fld   = t[26] ? e_res : 8'd0;
    rinc    = t[2] && (t[1] || t[0] || t[3]);
    mag     = {e_fld, t[25:3]} + {30'd0, rinc};
    sgn_res = (sum3_r == 28'd0 && sub3_r) ? 1'b0 : sgn3_r;
    origin_nxt = byp3_r ? bb3_r : {sgn_res, mag};
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      origin_r <= origin_nxt;
    end
  end

endmodule

[hw/rtl/ray_origin_offset.sv]
// ----------------------------------------------------------------------------
// ray_origin_offset: nudges a hit point off its surface along the normal
// Throughput: one item per cycle; every one of the four stages takes a new
// item in each cycle that the output is not stalled.
// Reset: rst_n (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
//
// Each axis runs through its own lane. Stage one decides the path: a point
// whose magnitude is at least 1/32 (or NaN) gets 256 times the normal,
// truncated and saturated, added to its bit pattern, negated for negative
// points. Smaller points take the float path, where the normal scaled by
// 2^-16 is added to the point by a three-stage single precision adder.
// The integer result rides along the adder stages so both paths share the
// same latency. A stall holds every full stage whose successor does not move; a stage
// moves on whenever it is empty or its successor moves.
module ray_origin_offset (
  input  logic          clk,
  input  logic          rst_n,
  ror_in_if.sink        in_ch,
  ror_out_if.source     out_ch
);
  import ror_pkg::*;

  pipe_en_t    en;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [31:0] pt   [Axes];
  logic [31:0] nm   [Axes];
  prep_t       prep [Axes];
  logic [31:0] org  [Axes];

  // Enable chain from the output backward.
  always_comb begin
    en.s4 = !v4_r || out_ch.ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_ch.ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_ch.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  assign pt[0] = in_ch.point_x;
  assign pt[1] = in_ch.point_y;
  assign pt[2] = in_ch.point_z;
  assign nm[0] = in_ch.normal_x;
  assign nm[1] = in_ch.normal_y;
  assign nm[2] = in_ch.normal_z;

  for (genvar a = 0; a < Axes; a++) begin : g_axis
    ror_prep u_prep (
      .clk    (clk),
      .en     (en),
      .point  (pt[a]),
      .normal (nm[a]),
      .prep_r (prep[a])
    );

    ror_fadd u_fadd (
      .clk      (clk),
      .en       (en),
      .prep     (prep[a]),
      .origin_r (org[a])
    );
  end

  assign out_ch.valid    = v4_r;
  assign out_ch.origin_x = org[0];
  assign out_ch.origin_y = org[1];
  assign out_ch.origin_z = org[2];

endmodule

[bench/ray_origin_offset_test.sv]
// ----------------------------------------------------------------------------
// ray_origin_offset_test: self-checking bench for the ray origin offset block
// Drives hit point and normal items through the input channel with random
// bursts and gaps, predicts each origin in the bench with its own integer and
// bit-exact single precision arithmetic, and compares every result item, in
// order, while the result channel stalls on its own random pattern.
// ----------------------------------------------------------------------------
module ray_origin_offset_test;
  import ror_pkg::*;

  // Extra wait at the end; the four stage pipeline is already empty by then.
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned FixLsb      = 170;  // fixed point unit is 2^-170
  localparam logic [31:0] OneThirtySecond = 32'h3D00_0000;

  typedef logic [319:0] wide_t;

  typedef struct packed {
    logic [31:0] point_x, point_y, point_z;
    logic [31:0] normal_x, normal_y, normal_z;
  } hit_t;

  typedef struct packed {
    logic [31:0] origin_x, origin_y, origin_z;
  } origin_t;

  logic clk;
  logic rst_n;

  ror_in_if  in_ch();
  ror_out_if out_ch();

  ray_origin_offset dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Origins still owed by the block, oldest first.
  origin_t     origin_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Sender burst control and the pressure knobs shared with the receiver.
  int unsigned burst_left;
  bit          no_gaps;
  int unsigned hold_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Prediction. All finite values are handled as exact fixed point numbers in
  // units of 2^-170, wide enough for the largest normal scaled by 2^-16, and
  // rounded back to single precision with round to nearest even.
  // --------------------------------------------------------------------------
  function automatic wide_t fixed_of(logic [31:0] b, int scale_down);
    wide_t m;
    int    pos;
    m   = (b[30:23] == 8'd0) ? wide_t'(b[22:0]) : wide_t'({1'b1, b[22:0]});
    pos = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150 + FixLsb - scale_down;
    return m << pos;
  endfunction

  function automatic logic [31:0] single_of(logic sgn, wide_t mag);
    int    msb;
    int    sh;
    wide_t q;
    wide_t rem;
    wide_t half;
    if (mag == '0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 319; i >= 0; i--) begin
      if (mag[i]) begin
        msb = i;
        break;
      end
    end
    // Keep 24 significant bits, but never go below the subnormal quantum.
    sh = msb - 23;
    if (sh < 21) sh = 21;
    q    = mag >> sh;
    rem  = mag - (q << sh);
    half = wide_t'(1) << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (q[24]) begin
      q  = q >> 1;
      sh = sh + 1;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    if (sh - 20 >= 255) return {sgn, ExpMax, 23'd0};
    return {sgn, 8'(sh - 20), q[22:0]};
  endfunction

  // Small points: p + n * 2^-16, both steps rounded as single precision.
  function automatic logic [31:0] float_nudge(logic [31:0] p, logic [31:0] n);
    logic [31:0] scaled;
    wide_t       pa;
    wide_t       sa;
    wide_t       mag;
    logic        sgn;
    if (n[30:23] == ExpMax && n[22:0] != '0) return QuietNan;
    // An infinite normal stays infinite, and a finite point cannot cancel it.
    if (n[30:23] == ExpMax) return {n[31], ExpMax, 23'd0};
    scaled = single_of(n[31], fixed_of(n, 16));
    pa = fixed_of(p, 0);
    sa = fixed_of(scaled, 0);
    if (p[31] == scaled[31]) begin
      mag = pa + sa;
      sgn = p[31];
    end else if (pa >= sa) begin
      mag = pa - sa;
      sgn = p[31];
    end else begin
      mag = sa - pa;
      sgn = scaled[31];
    end
    // An exact zero is negative only when both addends are negative zeros.
    if (mag == '0) sgn = p[31] & scaled[31];
    return single_of(sgn, mag);
  endfunction

  // 256 times the normal, truncated toward zero and saturated; NaN gives 0.
  function automatic logic [31:0] ulp_count(logic [31:0] n);
    logic [31:0] mag;
    if (n[30:23] == ExpMax && n[22:0] != '0) return '0;
    if (n[30:23] >= ExpOne) mag = OffsetSat;
    else if (n[30:23] < ExpOne - 8) mag = '0;
    else mag = {8'd0, 1'b1, n[22:0]} >> (OffsetShift - n[30:23]);
    return n[31] ? -mag : mag;
  endfunction

  function automatic logic [31:0] origin_axis(logic [31:0] p, logic [31:0] n);
    logic [31:0] step;
    logic        p_nan;
    if (p[30:0] < OneThirtySecond[30:0]) return float_nudge(p, n);
    // Large points move by whole ulps; a NaN point never counts as negative.
    p_nan = (p[30:23] == ExpMax) && (p[22:0] != '0);
    step  = ulp_count(n);
    if (p[31] && !p_nan) step = -step;
    return p + step;
  endfunction

  function automatic origin_t predict_origin(hit_t h);
    origin_t o;
    o.origin_x = origin_axis(h.point_x, h.normal_x);
    o.origin_y = origin_axis(h.point_y, h.normal_y);
    o.origin_z = origin_axis(h.point_z, h.normal_z);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts; a burst ends with valid low for a random
  // gap. Valid is lowered at the start of a send and by the drain task, each time
  // before a wait for a clock edge, so it never sees two assignments in one time step.
  // --------------------------------------------------------------------------
  task automatic send_hit(hit_t h);
    if (burst_left == 0 && !no_gaps) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    in_ch.valid    <= 1'b1;
    in_ch.point_x  <= h.point_x;
    in_ch.point_y  <= h.point_y;
    in_ch.point_z  <= h.point_z;
    in_ch.normal_x <= h.normal_x;
    in_ch.normal_y <= h.normal_y;
    in_ch.normal_z <= h.normal_z;
    do @(posedge clk); while (!in_ch.ready);
    origin_q.push_back(predict_origin(h));
    if (burst_left > 0) burst_left--;
  endtask

  // Let the pipeline empty with the input idle.
  task automatic wait_all_origins();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (origin_q.size() != 0) @(posedge clk);
  endtask

  // Points spread over both paths, the 1/32 boundary and the special values.
  function automatic logic [31:0] rand_point();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: r[30:23] = 8'($urandom_range(90, 121));        // float path
      3:       r[30:23] = 8'($urandom_range(0, 2));           // tiny, subnormal
      4:       r = {r[31], OneThirtySecond[30:0] + 31'($urandom_range(0, 3)) - 31'd2};
      5:       r[30:23] = ExpMax;                             // inf and NaN
      6, 7:    r[30:23] = 8'($urandom_range(122, 140));
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_normal();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r[30:23] = 8'($urandom_range(110, 126));    // inside [-1,1]
      4:          r[30:0]  = 31'h3F80_0000;                   // exactly one
      5:          r[30:23] = 8'($urandom_range(127, 254));    // saturates
      6:          r[30:23] = ExpMax;
      7:          r[30:23] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    return r;
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    h.point_x  = rand_point();
    h.point_y  = rand_point();
    h.point_z  = rand_point();
    h.normal_x = rand_normal();
    h.normal_y = rand_normal();
    h.normal_z = rand_normal();
    return h;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver. Ready follows a mode that is redrawn when the low six tick bits wrap:
  // always ready, random, or ready while the low two tick bits are zero. A requested hold-off overrides
  // the mode and keeps ready low for that many cycles.
  // --------------------------------------------------------------------------
  int unsigned stall_mode;
  int unsigned stall_tick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_tick   <= 0;
      stall_mode   <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd63) stall_mode <= $urandom_range(0, 2);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles  <= hold_cycles - 1;
      end else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= (stall_tick[1:0] == 2'd0);
        endcase
      end
    end
  end

  // Each accepted origin is compared with the oldest prediction.
  always @(posedge clk) begin
    origin_t exp_o;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (origin_q.size() == 0) begin
        $error("origin item with no prediction waiting: %h %h %h",
               out_ch.origin_x, out_ch.origin_y, out_ch.origin_z);
        mismatches++;
      end else begin
        exp_o = origin_q.pop_front();
        if (out_ch.origin_x !== exp_o.origin_x) begin
          $error("origin_x expected %h actual %h", exp_o.origin_x, out_ch.origin_x);
          mismatches++;
        end
        if (out_ch.origin_y !== exp_o.origin_y) begin
          $error("origin_y expected %h actual %h", exp_o.origin_y, out_ch.origin_y);
          mismatches++;
        end
        if (out_ch.origin_z !== exp_o.origin_z) begin
          $error("origin_z expected %h actual %h", exp_o.origin_z, out_ch.origin_z);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with work pending and no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (origin_q.size() == 0 && !in_ch.valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and each special case: the 1/32 boundary on both sides,
  // negative zero, subnormal and NaN points, saturating and NaN normals,
  // bit pattern wrap-around and a NaN produced on the float path.
  task automatic test_corner_cases();
    hit_t        h;
    logic [31:0] pts[12];
    logic [31:0] nrm[12];
    pts = '{32'h0000_0000, 32'h8000_0000, 32'h3D00_0000, 32'h3CFF_FFFF,
            32'hBD00_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'hB7A0_0000};
    nrm = '{32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'hC2C8_0000,
            32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
            32'h3BFF_FFFF, 32'hBC00_0000, 32'h3F7F_FFFF, 32'h8000_0001};
    for (int i = 0; i < 12; i++) begin
      h.point_x  = pts[i];
      h.point_y  = pts[(i + 5) % 12];
      h.point_z  = pts[(i + 9) % 12];
      h.normal_x = nrm[i];
      h.normal_y = nrm[(i + 3) % 12];
      h.normal_z = nrm[(i + 7) % 12];
      send_hit(h);
    end
    // All zeros and all ones on every field.
    send_hit('0);
    send_hit('1);
    // Three small points on the float path, one a negative zero with a zero normal.
    h = '{32'h3000_0001, 32'h0080_0000, 32'h8000_0000,
          32'h3E80_0000, 32'hBF80_0000, 32'h0000_0000};
    send_hit(h);
    wait_all_origins();
  endtask

  task automatic test_random_stream(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_hit(rand_hit());
    wait_all_origins();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the
  // input, while the sender keeps offering items back to back.
  task automatic test_output_holdoff();
    hold_cycles = 300;
    no_gaps     = 1'b1;
    for (int i = 0; i < 60; i++) send_hit(rand_hit());
    no_gaps = 1'b0;
    wait_all_origins();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.point_x  = '0;
    in_ch.point_y  = '0;
    in_ch.point_z  = '0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    mismatches     = 0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    hold_cycles    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_stream(800);
    test_output_holdoff();
    test_random_stream(780);

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && origin_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
